// ===== rtl/qgcs_pkg.sv =====
package qgcs_pkg;

    typedef struct packed {
        logic        cmd;
        logic [11:0] entry_index;
        logic [15:0] quat_x;
        logic [15:0] quat_y;
        logic [15:0] quat_z;
        logic [15:0] quat_w;
        logic [15:0] amplitude;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic        last_coord;
    } t_in_item;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last_pixel;
    } t_out_item;

    localparam int CFG_IW     = 3;
    localparam int NUMW       = 35;
    localparam int AGW        = 32;
    localparam int DENW       = 33;
    localparam int QW         = 16;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QW / DIV_BITS;
    localparam int CHAN_LAT   = 5 + DIV_STAGES;

endpackage

// ===== rtl/quaternion_grid_color_sampler.sv =====
// each sample transfer gives one result, loads give no result
// throughput: one item per cycle; a held result stalls the whole pipeline
// rate set by the 4 store banks read once per cycle and the 2-bit-per-stage divider
// reset: synchronous active low, clears valid bits and config registers to defaults
// grid store is not cleared; entries are undefined until loaded
module quaternion_grid_color_sampler #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  qgcs_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output qgcs_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qgcs_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import qgcs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WF    = $clog2(MAX_WIDTH + 1);
    localparam int HF    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int PXW   = 16 + WF;
    localparam int PYW   = 16 + HF;
    localparam int RFW   = YW + WF;
    localparam int WTW   = 33;
    localparam int EW    = 80;
    localparam int PW    = 49;
    localparam int SW    = 51;
    localparam int PIPE_LEN = 6 + CHAN_LAT;

    localparam logic [CFG_IW-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_GAIN_RED    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_GAIN_GREEN  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_GAIN_BLUE   = 3'd4;
    localparam logic              CMD_SAMPLE      = 1'b1;

    logic               en;
    logic [6:0]         r_gw, r_gh;
    logic signed [15:0] r_gain [3];
    logic [WF-1:0]      w_eff;
    logic [HF-1:0]      h_eff;

    // stage 1
    logic               r_v1, r_smp1, r_last1;
    logic [11:0]        r_idx1;
    logic [EW-1:0]      r_ent1;
    logic [PXW-1:0]     r_px1;
    logic [PYW-1:0]     r_py1;
    // stage 2
    logic               r_v2, r_smp2, r_last2;
    logic [11:0]        r_idx2;
    logic [EW-1:0]      r_ent2;
    logic [XW-1:0]      r_x0_2, r_x1_2;
    logic [AW-1:0]      r_row0_2, r_row1_2;
    logic [WTW-1:0]     r_wt2 [4];
    // stage 2 logic
    logic [XW-1:0]      x0, x1;
    logic [YW-1:0]      y0, y1;
    logic [WF:0]        x0p;
    logic [HF:0]        y0p;
    logic [RFW-1:0]     row0_full, row1_full;
    logic [16:0]        ax, bx, ay, by;
    logic [WTW-1:0]     n_wt [4];
    // memory
    logic [AW-1:0]      raddr [4];
    logic [EW-1:0]      rd [4];
    logic               we;
    // stage 3 and later
    logic [WTW-1:0]     r_wt3 [4];
    logic signed [PW-1:0] n_prod [5][4];
    logic signed [PW-1:0] r_prod4 [5][4];
    logic signed [SW-1:0] n_sum [5];
    logic signed [15:0] r_q5 [5];
    logic signed [31:0] r_sq6 [4];
    logic signed [31:0] r_xy6, r_wz6, r_xz6, r_wy6;
    logic signed [AGW-1:0] r_ag6 [3], r_ag7 [3], r_ag8 [3];
    logic [DENW-1:0]    r_n2_7, r_syz7, r_den8, n_den;
    logic signed [NUMW-1:0] r_ry7, r_rz7, r_num8 [3];
    logic [PIPE_LEN-1:0] r_sv, r_sl;
    logic signed [15:0] res [3];

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_gw == '0) begin
            w_eff = WF'(1);
        end else if (32'(r_gw) > MAX_WIDTH) begin
            w_eff = WF'(MAX_WIDTH);
        end else begin
            w_eff = WF'(r_gw);
        end
        if (r_gh == '0) begin
            h_eff = HF'(1);
        end else if (32'(r_gh) > MAX_HEIGHT) begin
            h_eff = HF'(MAX_HEIGHT);
        end else begin
            h_eff = HF'(r_gh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw      <= 7'd64;
            r_gh      <= 7'd64;
            r_gain[0] <= 16'sd4096;
            r_gain[1] <= 16'sd4096;
            r_gain[2] <= 16'sd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_gw      <= i_cfg_data[6:0];
                CFG_GRID_HEIGHT: r_gh      <= i_cfg_data[6:0];
                CFG_GAIN_RED:    r_gain[0] <= $signed(i_cfg_data);
                CFG_GAIN_GREEN:  r_gain[1] <= $signed(i_cfg_data);
                CFG_GAIN_BLUE:   r_gain[2] <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_sv <= '0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_sv <= {r_sv[PIPE_LEN-2:0], r_v2 && r_smp2};
        end
    end

    // grid mapping
    always_comb begin
        x0  = XW'(r_px1 >> 16);
        y0  = YW'(r_py1 >> 16);
        x0p = (WF+1)'(x0) + (WF+1)'(1);
        y0p = (HF+1)'(y0) + (HF+1)'(1);
        x1  = (x0p >= (WF+1)'(w_eff)) ? XW'(w_eff - WF'(1)) : XW'(x0p);
        y1  = (y0p >= (HF+1)'(h_eff)) ? YW'(h_eff - HF'(1)) : YW'(y0p);
        row0_full = RFW'(y0) * RFW'(w_eff);
        row1_full = RFW'(y1) * RFW'(w_eff);
        bx = {1'b0, r_px1[15:0]};
        by = {1'b0, r_py1[15:0]};
        ax = 17'h10000 - bx;
        ay = 17'h10000 - by;
        n_wt[0] = WTW'(ax * ay);
        n_wt[1] = WTW'(bx * ay);
        n_wt[2] = WTW'(ax * by);
        n_wt[3] = WTW'(bx * by);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_smp1  <= i_in_data.cmd == CMD_SAMPLE;
            r_last1 <= i_in_data.last_coord;
            r_idx1  <= i_in_data.entry_index;
            r_ent1  <= {i_in_data.amplitude, i_in_data.quat_w, i_in_data.quat_z,
                        i_in_data.quat_y, i_in_data.quat_x};
            r_px1   <= PXW'(i_in_data.coord_x ^ 16'h8000) * PXW'(w_eff - WF'(1));
            r_py1   <= PYW'(i_in_data.coord_y ^ 16'h8000) * PYW'(h_eff - HF'(1));

            r_smp2   <= r_smp1;
            r_last2  <= r_last1;
            r_idx2   <= r_idx1;
            r_ent2   <= r_ent1;
            r_x0_2   <= x0;
            r_x1_2   <= x1;
            r_row0_2 <= AW'(row0_full);
            r_row1_2 <= AW'(row1_full);
            r_wt2    <= n_wt;
            r_wt3    <= r_wt2;
        end
    end

    // neighbor reads, load writes in the same stage keep item order
    assign raddr[0] = r_row0_2 + AW'(r_x0_2);
    assign raddr[1] = r_row0_2 + AW'(r_x1_2);
    assign raddr[2] = r_row1_2 + AW'(r_x0_2);
    assign raddr[3] = r_row1_2 + AW'(r_x1_2);
    assign we = en && r_v2 && !r_smp2 && (32'(r_idx2) < DEPTH);

    for (genvar k = 0; k < 4; k++) begin : g_bank
        qgcs_store #(
            .DEPTH (DEPTH),
            .DW    (EW)
        ) u_store (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (AW'(r_idx2)),
            .i_wdata (r_ent2),
            .i_re    (en),
            .i_raddr (raddr[k]),
            .o_rdata (rd[k])
        );
    end

    // bilinear blend
    always_comb begin
        for (int c = 0; c < 5; c++) begin
            for (int k = 0; k < 4; k++) begin
                n_prod[c][k] = $signed(rd[k][16*c +: 16]) * $signed({1'b0, r_wt3[k]});
            end
            n_sum[c] = SW'(r_prod4[c][0]) + SW'(r_prod4[c][1]) + SW'(r_prod4[c][2])
                     + SW'(r_prod4[c][3]) + (SW'(1) <<< 31);
        end
    end

    always_comb begin
        n_den = (r_n2_7 == '0) ? (DENW'(1) << 30) : r_n2_7;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod4 <= n_prod;
            for (int c = 0; c < 5; c++) begin
                r_q5[c] <= n_sum[c][47:32];
            end
            for (int c = 0; c < 4; c++) begin
                r_sq6[c] <= r_q5[c] * r_q5[c];
            end
            r_xy6 <= r_q5[0] * r_q5[1];
            r_wz6 <= r_q5[3] * r_q5[2];
            r_xz6 <= r_q5[0] * r_q5[2];
            r_wy6 <= r_q5[3] * r_q5[1];
            for (int k = 0; k < 3; k++) begin
                r_ag6[k] <= r_q5[4] * r_gain[k];
            end
            r_n2_7 <= DENW'(r_sq6[0]) + DENW'(r_sq6[1]) + DENW'(r_sq6[2])
                    + DENW'(r_sq6[3]);
            r_syz7 <= DENW'(r_sq6[1]) + DENW'(r_sq6[2]);
            r_ry7  <= (NUMW'(r_xy6) + NUMW'(r_wz6)) <<< 1;
            r_rz7  <= (NUMW'(r_xz6) - NUMW'(r_wy6)) <<< 1;
            r_ag7  <= r_ag6;
            r_den8    <= n_den;
            r_num8[0] <= $signed(NUMW'(n_den)) - $signed(NUMW'({r_syz7, 1'b0}));
            r_num8[1] <= r_ry7;
            r_num8[2] <= r_rz7;
            r_ag8     <= r_ag7;
            r_sl      <= {r_sl[PIPE_LEN-2:0], r_last2};
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_chan
        qgcs_chan u_chan (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num8[k]),
            .i_ag  (r_ag8[k]),
            .i_den (r_den8),
            .o_res (res[k])
        );
    end

    assign o_out_valid           = r_sv[PIPE_LEN-1];
    assign o_out_data.red        = res[0];
    assign o_out_data.green      = res[1];
    assign o_out_data.blue       = res[2];
    assign o_out_data.last_pixel = r_sl[PIPE_LEN-1];

endmodule

// ===== rtl/qgcs_store.sv =====
module qgcs_store #(
    parameter int DEPTH = 4096,
    parameter int DW = 80,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/qgcs_chan.sv =====
module qgcs_chan (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [qgcs_pkg::NUMW-1:0]  i_num,
    input  logic signed [qgcs_pkg::AGW-1:0]   i_ag,
    input  logic        [qgcs_pkg::DENW-1:0]  i_den,
    output logic signed [qgcs_pkg::QW-1:0]    o_res
);
    import qgcs_pkg::*;

    localparam int MW  = DENW;
    localparam int MAW = AGW - 1;
    localparam int LOW = 17;
    localparam int PLW = LOW + MAW;
    localparam int PHW = MW - LOW + MAW;
    localparam int NRW = 64;
    localparam int DW  = DENW + 9;
    localparam int RW  = DW + QW;

    logic [MW-1:0]   r_mn1;
    logic [MAW-1:0]  r_ma1;
    logic [DENW-1:0] r_den1, r_den2;
    logic            r_neg1, r_neg2, r_neg3;
    logic [PLW-1:0]  r_pplo2;
    logic [PHW-1:0]  r_pphi2;
    logic [NRW-1:0]  r_nr3, r_lim3;
    logic [DW-1:0]   r_d3;

    logic [RW-1:0]   r_rem [DIV_STAGES+1];
    logic [QW-1:0]   r_q   [DIV_STAGES+1];
    logic [DW-1:0]   r_d   [DIV_STAGES+1];
    logic            r_ovf [DIV_STAGES+1];
    logic            r_neg [DIV_STAGES+1];
    logic [RW-1:0]   n_rem [DIV_STAGES];
    logic [QW-1:0]   n_q   [DIV_STAGES];

    logic signed [QW-1:0] r_res, n_res;

    always_comb begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            n_rem[s] = r_rem[s];
            n_q[s]   = r_q[s];
            for (int b = 0; b < DIV_BITS; b++) begin
                if (n_rem[s] >= (RW'(r_d[s]) << (QW - 1 - DIV_BITS * s - b))) begin
                    n_rem[s] = n_rem[s] - (RW'(r_d[s]) << (QW - 1 - DIV_BITS * s - b));
                    n_q[s][QW - 1 - DIV_BITS * s - b] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_neg[DIV_STAGES]) begin
            if (r_ovf[DIV_STAGES] || r_q[DIV_STAGES] > 16'h8000) begin
                n_res = 16'sh8000;
            end else begin
                n_res = -$signed(r_q[DIV_STAGES]);
            end
        end else begin
            if (r_ovf[DIV_STAGES] || r_q[DIV_STAGES] > 16'h7FFF) begin
                n_res = 16'sh7FFF;
            end else begin
                n_res = $signed(r_q[DIV_STAGES]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // magnitudes and sign
            r_mn1  <= (i_num < 0) ? MW'(-i_num) : MW'(i_num);
            r_ma1  <= (i_ag < 0) ? MAW'(-i_ag) : MAW'(i_ag);
            r_neg1 <= (i_num < 0) != (i_ag < 0);
            r_den1 <= i_den;
            // split product
            r_pplo2 <= r_mn1[LOW-1:0] * r_ma1;
            r_pphi2 <= r_mn1[MW-1:LOW] * r_ma1;
            r_den2  <= r_den1;
            r_neg2  <= r_neg1;
            // rounded numerator and saturation limit
            r_nr3  <= NRW'(r_pplo2) + (NRW'(r_pphi2) << LOW) + (NRW'(r_den2) << 8);
            r_lim3 <= (NRW'(r_den2) << 24) + (NRW'(r_den2) << 9);
            r_d3   <= DW'(r_den2) << 9;
            r_neg3 <= r_neg2;
            // divider entry
            r_rem[0] <= RW'(r_nr3);
            r_q[0]   <= '0;
            r_d[0]   <= r_d3;
            r_ovf[0] <= r_nr3 >= r_lim3;
            r_neg[0] <= r_neg3;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_q[s+1]   <= n_q[s];
                r_d[s+1]   <= r_d[s];
                r_ovf[s+1] <= r_ovf[s];
                r_neg[s+1] <= r_neg[s];
            end
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== tb/quaternion_grid_color_sampler_tb.sv =====
module quaternion_grid_color_sampler_tb;
    import qgcs_pkg::*;

    localparam int GRID_MAX  = 64;
    localparam int DEPTH     = GRID_MAX * GRID_MAX;
    localparam int LATENCY   = 21;
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_GAIN_RED    = 3'd2,
        REG_GAIN_GREEN  = 3'd3,
        REG_GAIN_BLUE   = 3'd4,
        REG_UNUSED      = 3'd7
    } t_reg_index;

    class color_checker;
        logic signed [15:0] quat_mem [4][DEPTH];
        logic signed [15:0] amp_mem [DEPTH];
        bit                 loaded [DEPTH];
        logic [6:0]         grid_w;
        logic [6:0]         grid_h;
        logic signed [15:0] gain [3];
        t_out_item          expected_colors [$];
        int                 errors;

        function new();
            grid_w = 7'd64;
            grid_h = 7'd64;
            foreach (gain[i]) gain[i] = 16'sd4096;
            foreach (loaded[i]) loaded[i] = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_index idx, logic [15:0] val);
            unique case (idx)
                REG_GRID_WIDTH:  grid_w = val[6:0];
                REG_GRID_HEIGHT: grid_h = val[6:0];
                REG_GAIN_RED:    gain[0] = val;
                REG_GAIN_GREEN:  gain[1] = val;
                REG_GAIN_BLUE:   gain[2] = val;
                default: ;
            endcase
        endfunction

        function longint clamp_size(logic [6:0] v);
            if (v < 1) return 1;
            if (v > GRID_MAX) return GRID_MAX;
            return longint'(v);
        endfunction

        // four corner entries and the bilinear weights of a coordinate
        function void corners(logic [15:0] cx, logic [15:0] cy,
                              output int idx[4], output longint wt[4]);
            longint w, h, px, py, x0, y0, x1, y1, fx, fy;
            w = clamp_size(grid_w);
            h = clamp_size(grid_h);
            px = longint'(cx ^ 16'h8000) * (w - 1);
            py = longint'(cy ^ 16'h8000) * (h - 1);
            x0 = px >> 16;
            y0 = py >> 16;
            fx = px & 64'hFFFF;
            fy = py & 64'hFFFF;
            x1 = (x0 + 1 >= w) ? w - 1 : x0 + 1;
            y1 = (y0 + 1 >= h) ? h - 1 : y0 + 1;
            idx[0] = int'(y0 * w + x0);
            idx[1] = int'(y0 * w + x1);
            idx[2] = int'(y1 * w + x0);
            idx[3] = int'(y1 * w + x1);
            wt[0] = (65536 - fx) * (65536 - fy);
            wt[1] = fx * (65536 - fy);
            wt[2] = (65536 - fx) * fy;
            wt[3] = fx * fy;
        endfunction

        function logic [15:0] scale_channel(longint num, longint ag, longint den);
            bit                neg;
            longint unsigned   mn, ma, d, qq;
            neg = (num < 0) != (ag < 0);
            mn = (num < 0) ? -num : num;
            ma = (ag < 0) ? -ag : ag;
            d = den << 9;
            qq = (mn * ma + d / 2) / d;
            if (neg) return (qq > 32768) ? 16'h8000 : 16'(-longint'(qq));
            return (qq > 32767) ? 16'h7FFF : 16'(qq);
        endfunction

        function t_out_item predict_color(t_in_item it);
            int        idx[4];
            longint    wt[4];
            longint    q[4];
            longint    s, amp, n2, den, rx, ry, rz;
            t_out_item res;
            corners(it.coord_x, it.coord_y, idx, wt);
            for (int c = 0; c < 4; c++) begin
                s = 0;
                for (int k = 0; k < 4; k++) s += longint'(quat_mem[c][idx[k]]) * wt[k];
                q[c] = (s + (64'sd1 << 31)) >>> 32;
            end
            s = 0;
            for (int k = 0; k < 4; k++) s += longint'(amp_mem[idx[k]]) * wt[k];
            amp = (s + (64'sd1 << 31)) >>> 32;
            n2 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3];
            den = (n2 == 0) ? (64'sd1 << 30) : n2;
            rx = den - 2 * (q[1] * q[1] + q[2] * q[2]);
            ry = 2 * (q[0] * q[1] + q[3] * q[2]);
            rz = 2 * (q[0] * q[2] - q[3] * q[1]);
            res.red        = scale_channel(rx, amp * longint'(gain[0]), den);
            res.green      = scale_channel(ry, amp * longint'(gain[1]), den);
            res.blue       = scale_channel(rz, amp * longint'(gain[2]), den);
            res.last_pixel = it.last_coord;
            return res;
        endfunction

        function void note_transfer(t_in_item it);
            if (it.cmd == CMD_LOAD) begin
                quat_mem[0][it.entry_index] = it.quat_x;
                quat_mem[1][it.entry_index] = it.quat_y;
                quat_mem[2][it.entry_index] = it.quat_z;
                quat_mem[3][it.entry_index] = it.quat_w;
                amp_mem[it.entry_index] = it.amplitude;
                loaded[it.entry_index] = 1'b1;
            end else begin
                expected_colors.push_back(predict_color(it));
            end
        endfunction

        function void check_pixel(t_out_item got);
            t_out_item exp_px;
            if (expected_colors.size() == 0) begin
                $error("unexpected pixel transfer %h", got);
                errors++;
                return;
            end
            exp_px = expected_colors.pop_front();
            if (got.red !== exp_px.red) begin
                $error("red: expected %h, actual %h", exp_px.red, got.red);
                errors++;
            end
            if (got.green !== exp_px.green) begin
                $error("green: expected %h, actual %h", exp_px.green, got.green);
                errors++;
            end
            if (got.blue !== exp_px.blue) begin
                $error("blue: expected %h, actual %h", exp_px.blue, got.blue);
                errors++;
            end
            if (got.last_pixel !== exp_px.last_pixel) begin
                $error("last_pixel: expected %b, actual %b", exp_px.last_pixel, got.last_pixel);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_in_valid = 1'b0;
    logic         o_in_ready;
    t_in_item     i_in_data = '0;
    logic         o_out_valid;
    logic         i_out_ready = 1'b0;
    t_out_item    o_out_data;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;

    int send_idle = 19;
    int recv_idle = 58;

    color_checker checker_h = new();

    quaternion_grid_color_sampler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            checker_h.check_pixel(o_out_data);
        end
    end

    task automatic push_item(t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        checker_h.note_transfer(it);
    endtask

    task automatic load_entry(int idx, logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                              logic [15:0] qw, logic [15:0] a);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.cmd = CMD_LOAD;
        it.entry_index = idx[11:0];
        it.quat_x = qx;
        it.quat_y = qy;
        it.quat_z = qz;
        it.quat_w = qw;
        it.amplitude = a;
        push_item(it);
    endtask

    // unwritten neighbors get loaded first so no sample reads undefined entries
    task automatic sample_at(logic [15:0] cx, logic [15:0] cy, logic last);
        t_in_item it;
        int       idx[4];
        longint   wt[4];
        checker_h.corners(cx, cy, idx, wt);
        foreach (idx[k]) begin
            if (!checker_h.loaded[idx[k]]) begin
                load_entry(idx[k], 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
            end
        end
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.cmd = CMD_SAMPLE;
        it.coord_x = cx;
        it.coord_y = cy;
        it.last_coord = last;
        push_item(it);
    endtask

    task automatic write_reg(t_reg_index idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        checker_h.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (checker_h.expected_colors.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic random_items(int n);
        int idx;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 30) begin
                idx = ($urandom_range(1) == 0) ? $urandom_range(DEPTH - 1)
                    : $urandom_range(int'(checker_h.clamp_size(checker_h.grid_w)
                                     * checker_h.clamp_size(checker_h.grid_h)) - 1);
                load_entry(idx, 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
            end else begin
                sample_at(16'($urandom), 16'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default grid, corner entries at extremes, zero quaternion at entry 0
        load_entry(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        sample_at(16'h8000, 16'h8000, 1'b0);
        load_entry(1, 16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h8000);
        load_entry(64, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        load_entry(65, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1000);
        load_entry(DEPTH - 1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        sample_at(16'h8000, 16'h8000, 1'b1);
        sample_at(16'h8400, 16'h8200, 1'b0);
        sample_at(16'h7FFF, 16'h7FFF, 1'b1);
        sample_at(16'h0000, 16'h0000, 1'b0);
        sample_at(16'h7FFF, 16'h8000, 1'b1);
        sample_at(16'h8000, 16'h7FFF, 1'b0);
        sample_at(16'hFFFF, 16'h0001, 1'b1);
        random_items(60);
        drain();

        write_reg(REG_GRID_WIDTH, 16'd1);
        write_reg(REG_GRID_HEIGHT, 16'd1);
        write_reg(REG_GAIN_RED, 16'h8000);
        write_reg(REG_GAIN_GREEN, 16'h7FFF);
        write_reg(REG_GAIN_BLUE, 16'h0000);
        random_items(120);
        drain();

        send_idle = 58;
        recv_idle = 19;
        write_reg(REG_GRID_WIDTH, 16'd0);
        write_reg(REG_GRID_HEIGHT, 16'd127);
        write_reg(REG_GAIN_RED, 16'($urandom));
        write_reg(REG_GAIN_GREEN, 16'($urandom));
        write_reg(REG_GAIN_BLUE, 16'($urandom));
        random_items(120);
        drain();

        write_reg(REG_GRID_WIDTH, 16'hFFFF);
        write_reg(REG_GRID_HEIGHT, 16'd2);
        write_reg(REG_GAIN_BLUE, 16'h8000);
        write_reg(REG_UNUSED, 16'($urandom));
        random_items(120);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_GRID_WIDTH, 16'd2);
        write_reg(REG_GRID_HEIGHT, 16'd3);
        write_reg(REG_GAIN_RED, 16'h1000);
        write_reg(REG_GAIN_GREEN, 16'hF000);
        write_reg(REG_GAIN_BLUE, 16'h2000);
        random_items(120);
        drain();

        write_reg(REG_GRID_WIDTH, 16'($urandom_range(1, 8)));
        write_reg(REG_GRID_HEIGHT, 16'($urandom_range(1, 8)));
        write_reg(REG_GAIN_RED, 16'd4096);
        write_reg(REG_GAIN_GREEN, 16'd4096);
        write_reg(REG_GAIN_BLUE, 16'd4096);
        random_items(120);
        drain();

        if (checker_h.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
